/* hw/rtl/csr_acc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the CSR access unit.
// No dependencies; imported by every module of the block.
package csr_acc_pkg;

  // Field widths of the access request and result
  localparam int FUNC_W  = 2;
  localparam int ADDR_W  = 12;
  localparam int DATA_W  = 32;
  localparam int PRIV_W  = 2;
  localparam int REG_W   = 5;

  // State widths
  localparam int STATUS_W  = 13;
  localparam int EDELEG_W  = 16;
  localparam int IRQ_W     = 8;

  // Fully writable scratch/trap registers
  localparam int PLAIN_COUNT = 10;
  localparam int SLOT_W      = $clog2(PLAIN_COUNT);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Writable masks and constant values
  localparam logic [DATA_W-1:0] MASK_MSTATUS = 32'h0000_1baa;
  localparam logic [DATA_W-1:0] MASK_SSTATUS = 32'h0000_0122;
  localparam logic [DATA_W-1:0] MASK_IRQ     = 32'h0000_00aa;
  localparam logic [DATA_W-1:0] MASK_MEDELEG = 32'h0000_ffff;
  localparam logic [DATA_W-1:0] MISA_VALUE   = 32'h4000_1100;

  // CSR numbers
  localparam logic [ADDR_W-1:0] ADR_SSTATUS   = 12'h100;
  localparam logic [ADDR_W-1:0] ADR_SIE       = 12'h104;
  localparam logic [ADDR_W-1:0] ADR_STVEC     = 12'h105;
  localparam logic [ADDR_W-1:0] ADR_SSCRATCH  = 12'h140;
  localparam logic [ADDR_W-1:0] ADR_SEPC      = 12'h141;
  localparam logic [ADDR_W-1:0] ADR_SCAUSE    = 12'h142;
  localparam logic [ADDR_W-1:0] ADR_STVAL     = 12'h143;
  localparam logic [ADDR_W-1:0] ADR_SIP       = 12'h144;
  localparam logic [ADDR_W-1:0] ADR_MSTATUS   = 12'h300;
  localparam logic [ADDR_W-1:0] ADR_MISA      = 12'h301;
  localparam logic [ADDR_W-1:0] ADR_MEDELEG   = 12'h302;
  localparam logic [ADDR_W-1:0] ADR_MIDELEG   = 12'h303;
  localparam logic [ADDR_W-1:0] ADR_MIE       = 12'h304;
  localparam logic [ADDR_W-1:0] ADR_MTVEC     = 12'h305;
  localparam logic [ADDR_W-1:0] ADR_MSCRATCH  = 12'h340;
  localparam logic [ADDR_W-1:0] ADR_MEPC      = 12'h341;
  localparam logic [ADDR_W-1:0] ADR_MCAUSE    = 12'h342;
  localparam logic [ADDR_W-1:0] ADR_MTVAL     = 12'h343;
  localparam logic [ADDR_W-1:0] ADR_MIP       = 12'h344;
  localparam logic [ADDR_W-1:0] ADR_MVENDORID = 12'hf11;
  localparam logic [ADDR_W-1:0] ADR_MARCHID   = 12'hf12;
  localparam logic [ADDR_W-1:0] ADR_MIMPID    = 12'hf13;
  localparam logic [ADDR_W-1:0] ADR_MHARTID   = 12'hf14;

  // Slot numbers of the plain registers
  localparam logic [SLOT_W-1:0] SLOT_MTVEC    = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_MSCRATCH = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_MEPC     = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_MCAUSE   = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_MTVAL    = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_STVEC    = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_SSCRATCH = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_SEPC     = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_SCAUSE   = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_STVAL    = 4'd9;

  // Register class selected by the address decoder
  typedef logic [3:0] csr_kind_t;
  localparam csr_kind_t KIND_NONE    = 4'd0;
  localparam csr_kind_t KIND_PLAIN   = 4'd1;
  localparam csr_kind_t KIND_SSTATUS = 4'd2;
  localparam csr_kind_t KIND_SIE     = 4'd3;
  localparam csr_kind_t KIND_SIP     = 4'd4;
  localparam csr_kind_t KIND_MSTATUS = 4'd5;
  localparam csr_kind_t KIND_MISA    = 4'd6;
  localparam csr_kind_t KIND_MEDELEG = 4'd7;
  localparam csr_kind_t KIND_MIDELEG = 4'd8;
  localparam csr_kind_t KIND_MIE     = 4'd9;
  localparam csr_kind_t KIND_MIP     = 4'd10;
  localparam csr_kind_t KIND_ZERO    = 4'd11;

  // Request and result payloads
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] csr_address;
    logic [DATA_W-1:0] write_value;
    logic [PRIV_W-1:0] privilege;
    logic [REG_W-1:0]  dest_reg;
  } csr_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [REG_W-1:0]  dest_reg_out;
    logic              fault;
  } csr_rsp_t;

  // Decoder result handed to the register file
  typedef struct packed {
    csr_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    logic              fault;
  } csr_dec_t;

  // Apply write / set / clear under a writable mask; other codes keep the value
  function automatic logic [DATA_W-1:0] apply_op(input logic [DATA_W-1:0] old,
                                                 input logic [DATA_W-1:0] v,
                                                 input logic [FUNC_W-1:0] func,
                                                 input logic [DATA_W-1:0] mask);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] res;
    m = v & mask;
    case (func)
      FUNC_WRITE: res = (old & ~mask) | m;
      FUNC_SET:   res = old | m;
      FUNC_CLEAR: res = old & ~m;
      default:    res = old;
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/csr_acc_decode.sv */
`timescale 1ns / 1ps
// Address decoder and privilege check for the CSR access unit.
// Depends on csr_acc_pkg.
module csr_acc_decode
  import csr_acc_pkg::*;
(
  input  logic [ADDR_W-1:0] csr_address,
  input  logic [PRIV_W-1:0] privilege,
  output csr_dec_t          dec
);

  csr_kind_t         kind;
  logic [SLOT_W-1:0] slot;

  // Map the CSR number to a register class and plain slot
  always_comb begin
    kind = KIND_PLAIN;
    slot = SLOT_MTVEC;
    case (csr_address)
      ADR_MTVEC:     slot = SLOT_MTVEC;
      ADR_MSCRATCH:  slot = SLOT_MSCRATCH;
      ADR_MEPC:      slot = SLOT_MEPC;
      ADR_MCAUSE:    slot = SLOT_MCAUSE;
      ADR_MTVAL:     slot = SLOT_MTVAL;
      ADR_STVEC:     slot = SLOT_STVEC;
      ADR_SSCRATCH:  slot = SLOT_SSCRATCH;
      ADR_SEPC:      slot = SLOT_SEPC;
      ADR_SCAUSE:    slot = SLOT_SCAUSE;
      ADR_STVAL:     slot = SLOT_STVAL;
      ADR_SSTATUS:   kind = KIND_SSTATUS;
      ADR_SIE:       kind = KIND_SIE;
      ADR_SIP:       kind = KIND_SIP;
      ADR_MSTATUS:   kind = KIND_MSTATUS;
      ADR_MISA:      kind = KIND_MISA;
      ADR_MEDELEG:   kind = KIND_MEDELEG;
      ADR_MIDELEG:   kind = KIND_MIDELEG;
      ADR_MIE:       kind = KIND_MIE;
      ADR_MIP:       kind = KIND_MIP;
      ADR_MVENDORID: kind = KIND_ZERO;
      ADR_MARCHID:   kind = KIND_ZERO;
      ADR_MIMPID:    kind = KIND_ZERO;
      ADR_MHARTID:   kind = KIND_ZERO;
      default:       kind = KIND_NONE;
    endcase
  end

  // Fault on an absent CSR or when the address needs more privilege
  assign dec.kind  = kind;
  assign dec.slot  = slot;
  assign dec.fault = (kind == KIND_NONE) || (csr_address[9:8] > privilege);

endmodule

/* hw/rtl/csr_acc_regs.sv */
`timescale 1ns / 1ps
// Machine/supervisor CSR state with read mux and masked read-modify-write.
// Depends on csr_acc_pkg.
module csr_acc_regs
  import csr_acc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              commit,
  input  csr_dec_t          dec,
  input  logic [FUNC_W-1:0] func,
  input  logic [DATA_W-1:0] write_value,
  output logic [DATA_W-1:0] read_data
);

  logic [STATUS_W-1:0] status_bits;
  logic [EDELEG_W-1:0] exception_delegation;
  logic [IRQ_W-1:0]    interrupt_delegation;
  logic [IRQ_W-1:0]    interrupt_enable;
  logic [IRQ_W-1:0]    interrupt_pending;
  logic [DATA_W-1:0]   plain_registers [PLAIN_COUNT];

  logic [DATA_W-1:0] plain_old;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] view;
  logic [DATA_W-1:0] value_next;

  assign plain_old = plain_registers[dec.slot];

  // Select the visible value, the full register behind it and its write mask
  always_comb begin
    base = '0;
    mask = '0;
    view = '0;
    case (dec.kind)
      KIND_PLAIN: begin
        base = plain_old;
        mask = '1;
        view = plain_old;
      end
      KIND_SSTATUS: begin
        base = DATA_W'(status_bits);
        mask = MASK_SSTATUS;
        view = DATA_W'(status_bits) & MASK_SSTATUS;
      end
      KIND_SIE: begin
        base = DATA_W'(interrupt_enable);
        mask = DATA_W'(interrupt_delegation);
        view = DATA_W'(interrupt_enable & interrupt_delegation);
      end
      KIND_SIP: begin
        base = DATA_W'(interrupt_pending);
        mask = DATA_W'(interrupt_delegation);
        view = DATA_W'(interrupt_pending & interrupt_delegation);
      end
      KIND_MSTATUS: begin
        base = DATA_W'(status_bits);
        mask = MASK_MSTATUS;
        view = DATA_W'(status_bits);
      end
      KIND_MISA: begin
        view = MISA_VALUE;
      end
      KIND_MEDELEG: begin
        base = DATA_W'(exception_delegation);
        mask = MASK_MEDELEG;
        view = DATA_W'(exception_delegation);
      end
      KIND_MIDELEG: begin
        base = DATA_W'(interrupt_delegation);
        mask = MASK_IRQ;
        view = DATA_W'(interrupt_delegation);
      end
      KIND_MIE: begin
        base = DATA_W'(interrupt_enable);
        mask = MASK_IRQ;
        view = DATA_W'(interrupt_enable);
      end
      KIND_MIP: begin
        base = DATA_W'(interrupt_pending);
        mask = MASK_IRQ;
        view = DATA_W'(interrupt_pending);
      end
      default: begin
        view = '0;
      end
    endcase
  end

  assign value_next = apply_op(base, write_value, func, mask);
  assign read_data  = view;

  // Write back the modified register on a committed access
  always_ff @(posedge clk) begin
    if (rst) begin
      status_bits          <= '0;
      exception_delegation <= '0;
      interrupt_delegation <= '0;
      interrupt_enable     <= '0;
      interrupt_pending    <= '0;
      for (int i = 0; i < PLAIN_COUNT; i++) begin
        plain_registers[i] <= '0;
      end
    end else if (commit) begin
      case (dec.kind)
        KIND_PLAIN:   plain_registers[dec.slot] <= value_next;
        KIND_SSTATUS: status_bits               <= value_next[STATUS_W-1:0];
        KIND_MSTATUS: status_bits               <= value_next[STATUS_W-1:0];
        KIND_SIE:     interrupt_enable          <= value_next[IRQ_W-1:0];
        KIND_MIE:     interrupt_enable          <= value_next[IRQ_W-1:0];
        KIND_SIP:     interrupt_pending         <= value_next[IRQ_W-1:0];
        KIND_MIP:     interrupt_pending         <= value_next[IRQ_W-1:0];
        KIND_MEDELEG: exception_delegation      <= value_next[EDELEG_W-1:0];
        KIND_MIDELEG: interrupt_delegation      <= value_next[IRQ_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/riscv_csr_access_unit_core.sv */
`timescale 1ns / 1ps
// Top level of the CSR access unit: request register, decode, CSR file, result register.
// Depends on csr_acc_pkg, csr_acc_decode and csr_acc_regs.
//
//   channel | signals                  | direction | payload
//   --------+--------------------------+-----------+----------------------------
//   req     | req_valid, req_stall     | in        | csr_req_t (func .. dest_reg)
//   rsp     | rsp_valid, rsp_stall     | out       | csr_rsp_t (read_data, fault)
//
// One access per cycle sustained while rsp_stall stays low; an access passes through the
// request register and then the result register before its result can transfer.
// The CSR read-modify-write of a non-faulting access happens when it moves from the
// request register to the result register.
// Reset clears both valid flags and all CSR state to zero.
// A stalled result holds the request register; req_stall rises only when both
// stages are full and rsp_stall is high.
module riscv_csr_access_unit_core
  import csr_acc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  csr_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output csr_rsp_t rsp
);

  logic      req_held_valid;
  csr_req_t  req_held;
  logic      advance;
  csr_dec_t  dec;
  logic [DATA_W-1:0] old_value;

  // Advance the held request when the result register is free or drains
  assign advance   = req_held_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_held_valid && !advance;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_held_valid <= 1'b0;
    end else if (!req_stall) begin
      req_held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      req_held <= req;
    end
  end

  csr_acc_decode u_decode (
    .csr_address (req_held.csr_address),
    .privilege   (req_held.privilege),
    .dec         (dec)
  );

  csr_acc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .commit      (advance && !dec.fault),
    .dec         (dec),
    .func        (req_held.func),
    .write_value (req_held.write_value),
    .read_data   (old_value)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.read_data    <= dec.fault ? '0 : old_value;
      rsp.dest_reg_out <= req_held.dest_reg;
      rsp.fault        <= dec.fault;
    end
  end

endmodule

/* hw/rtl/csr_acc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the CSR access unit, bound to the top level.
// Depends on csr_acc_pkg and riscv_csr_access_unit_core.
module csr_acc_checker
  import csr_acc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input csr_req_t req,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input csr_rsp_t rsp
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result dropped or changed");

  // Hold a stalled request
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request dropped or changed");

  // Drop results during reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // Stall requests only when both stages are full and the sink is stalled
  a_req_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled while result side can drain");

  // A faulting access returns zero
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.fault |-> rsp.read_data == '0)
    else $error("fault with nonzero read data");

endmodule

bind riscv_csr_access_unit_core csr_acc_checker u_csr_acc_checker (.*);
